/* hw/rtl/catmull_rom_to_bezier_smoother_core_defines.svh */
// assertion macros for the smoother core, clocked on i_clk with i_rst_n
`ifndef CATMULL_ROM_TO_BEZIER_SMOOTHER_CORE_DEFINES_SVH
`define CATMULL_ROM_TO_BEZIER_SMOOTHER_CORE_DEFINES_SVH

// same-cycle implication
`define CRB_CHECK_SAME(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("crb check failed");

// next-cycle implication
`define CRB_CHECK_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("crb check failed");

`endif

/* hw/rtl/crb_pkg.sv */
`default_nettype none

package crb_pkg;

    localparam int CRB_COORD_BITS = 32;
    localparam int CRB_STEP_BITS  = 3;

    typedef logic signed [CRB_COORD_BITS-1:0] t_coord;
    typedef logic [CRB_STEP_BITS-1:0]         t_step;
    typedef logic [1:0]                       t_tap;
    typedef logic [1:0]                       t_seen;

    typedef struct packed {
        t_coord vx;
        t_coord vy;
        logic   vlast;
    } t_vertex;

    typedef struct packed {
        t_coord px;
        t_coord py;
        logic   point_role;
        logic   run_end;
    } t_point;

    localparam logic ROLE_ANCHOR  = 1'b0;
    localparam logic ROLE_CONTROL = 1'b1;

    localparam t_seen SEEN_HEAD = 2'd2;
    localparam t_seen SEEN_MAX  = 2'd3;

    // points of one job, in emit order
    localparam t_step STEP_HEAD    = 3'd0;
    localparam t_step STEP_SEG_C1  = 3'd1;
    localparam t_step STEP_SEG_C2  = 3'd2;
    localparam t_step STEP_SEG_END = 3'd3;
    localparam t_step STEP_FIN_C1  = 3'd4;
    localparam t_step STEP_FIN_C2  = 3'd5;
    localparam t_step STEP_FIN_END = 3'd6;

    localparam t_tap TAP_P0 = 2'd0;
    localparam t_tap TAP_P1 = 2'd1;
    localparam t_tap TAP_P2 = 2'd2;
    localparam t_tap TAP_P3 = 2'd3;

    // floor(m / 3) = (m * CRB_RECIP3) >> CRB_RECIP_SHIFT for m below 2^(CRB_COORD_BITS-1)+1
    localparam int CRB_RECIP_SHIFT = CRB_COORD_BITS + 1;
    localparam logic [63:0] CRB_RECIP3_FULL = ((64'd1 << CRB_RECIP_SHIFT) + 64'd2) / 64'd3;
    localparam logic [CRB_COORD_BITS-1:0] CRB_RECIP3 = CRB_RECIP3_FULL[CRB_COORD_BITS-1:0];

    localparam t_coord CRB_COORD_MAX = {1'b0, {(CRB_COORD_BITS-1){1'b1}}};
    localparam t_coord CRB_COORD_MIN = {1'b1, {(CRB_COORD_BITS-1){1'b0}}};

    typedef struct packed {
        t_coord [3:0] x;
        t_coord [3:0] y;
        t_step        first;
        t_step        last;
    } t_job;

    typedef struct packed {
        t_tap base;
        t_tap hi;
        t_tap lo;
        logic sub;
        logic role;
        logic run_end;
    } t_op;

    typedef struct packed {
        logic   valid;
        t_coord base_x;
        t_coord hi_x;
        t_coord lo_x;
        t_coord base_y;
        t_coord hi_y;
        t_coord lo_y;
        logic   sub;
        logic   role;
        logic   run_end;
    } t_issue;

    typedef struct packed {
        logic busy;
        logic free;
    } t_seq_stat;

    function automatic t_op op_for_step(input t_step s);
        t_op op;
        case (s)
            STEP_HEAD: begin
                op = '{base: TAP_P1, hi: TAP_P1, lo: TAP_P1, sub: 1'b0,
                       role: ROLE_ANCHOR, run_end: 1'b0};
            end
            STEP_SEG_C1: begin
                op = '{base: TAP_P1, hi: TAP_P2, lo: TAP_P0, sub: 1'b0,
                       role: ROLE_CONTROL, run_end: 1'b0};
            end
            STEP_SEG_C2: begin
                op = '{base: TAP_P2, hi: TAP_P3, lo: TAP_P1, sub: 1'b1,
                       role: ROLE_CONTROL, run_end: 1'b0};
            end
            STEP_SEG_END: begin
                op = '{base: TAP_P2, hi: TAP_P2, lo: TAP_P2, sub: 1'b0,
                       role: ROLE_ANCHOR, run_end: 1'b0};
            end
            STEP_FIN_C1: begin
                op = '{base: TAP_P2, hi: TAP_P3, lo: TAP_P1, sub: 1'b0,
                       role: ROLE_CONTROL, run_end: 1'b0};
            end
            STEP_FIN_C2: begin
                op = '{base: TAP_P3, hi: TAP_P3, lo: TAP_P2, sub: 1'b1,
                       role: ROLE_CONTROL, run_end: 1'b0};
            end
            STEP_FIN_END: begin
                op = '{base: TAP_P3, hi: TAP_P3, lo: TAP_P3, sub: 1'b0,
                       role: ROLE_ANCHOR, run_end: 1'b1};
            end
            default: begin
                op = '{base: TAP_P1, hi: TAP_P1, lo: TAP_P1, sub: 1'b0,
                       role: ROLE_ANCHOR, run_end: 1'b0};
            end
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/crb_window.sv */
`default_nettype none

module crb_window
    import crb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_cfg_we,
    input  wire logic    i_cfg_data,
    input  wire logic    i_accept,
    input  wire t_vertex i_vertex,
    output logic         o_job_load,
    output t_job         o_job,
    output t_seen        o_seen
);

    logic   r_enable;
    t_seen  r_seen;
    t_seen  n_seen;
    t_coord r_wx [0:2];
    t_coord r_wy [0:2];
    logic   w_head;
    logic   w_body;

    assign w_head     = r_enable && (r_seen == SEEN_HEAD);
    assign w_body     = r_enable && (r_seen == SEEN_MAX);
    assign o_job_load = w_head || w_body;
    assign o_seen     = r_seen;

    // first segment duplicates the first vertex as its own neighbour
    always_comb begin
        o_job.x[0] = w_head ? r_wx[1] : r_wx[0];
        o_job.y[0] = w_head ? r_wy[1] : r_wy[0];
        o_job.x[1] = r_wx[1];
        o_job.y[1] = r_wy[1];
        o_job.x[2] = r_wx[2];
        o_job.y[2] = r_wy[2];
        o_job.x[3] = i_vertex.vx;
        o_job.y[3] = i_vertex.vy;
        o_job.first = w_head ? STEP_HEAD : STEP_SEG_C1;
        o_job.last  = i_vertex.vlast ? STEP_FIN_END : STEP_SEG_END;
    end

    always_comb begin
        n_seen = r_seen;
        if (i_accept) begin
            if (i_vertex.vlast) begin
                n_seen = '0;
            end else if (r_seen != SEEN_MAX) begin
                n_seen = r_seen + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_seen   <= '0;
            for (int i = 0; i < 3; i++) begin
                r_wx[i] <= '0;
                r_wy[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_enable <= i_cfg_data;
            end
            r_seen <= n_seen;
            if (i_accept) begin
                if (i_vertex.vlast) begin
                    for (int i = 0; i < 3; i++) begin
                        r_wx[i] <= '0;
                        r_wy[i] <= '0;
                    end
                end else begin
                    r_wx[0] <= r_wx[1];
                    r_wy[0] <= r_wy[1];
                    r_wx[1] <= r_wx[2];
                    r_wy[1] <= r_wy[2];
                    r_wx[2] <= i_vertex.vx;
                    r_wy[2] <= i_vertex.vy;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/crb_seq.sv */
`default_nettype none

module crb_seq
    import crb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_load,
    input  wire t_job i_job,
    input  wire logic i_adv,
    output t_seq_stat o_stat,
    output t_issue    o_issue
);

    logic  r_busy;
    t_step r_step;
    t_job  r_job;
    logic  w_at_last;
    t_op   w_op;

    assign w_at_last   = (r_step == r_job.last);
    assign o_stat.busy = r_busy;
    assign o_stat.free = !r_busy || (i_adv && w_at_last);

    assign w_op = op_for_step(r_step);

    always_comb begin
        o_issue.valid   = r_busy;
        o_issue.base_x  = r_job.x[w_op.base];
        o_issue.hi_x    = r_job.x[w_op.hi];
        o_issue.lo_x    = r_job.x[w_op.lo];
        o_issue.base_y  = r_job.y[w_op.base];
        o_issue.hi_y    = r_job.y[w_op.hi];
        o_issue.lo_y    = r_job.y[w_op.lo];
        o_issue.sub     = w_op.sub;
        o_issue.role    = w_op.role;
        o_issue.run_end = w_op.run_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_HEAD;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_step <= i_job.first;
        end else if (i_adv && r_busy) begin
            if (w_at_last) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + CRB_STEP_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_job <= i_job;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/crb_point.sv */
`default_nettype none

module crb_point
    import crb_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_issue i_issue,
    input  wire logic   i_out_ready,
    output logic        o_adv,
    output logic        o_out_valid,
    output t_point      o_out_data
);

    localparam int W = CRB_COORD_BITS;

    // stage 1: chord, sign and half magnitude
    logic signed [W:0] w_diff_x;
    logic signed [W:0] w_diff_y;
    logic [W:0]        w_mag_x;
    logic [W:0]        w_mag_y;

    logic          r_s1_valid;
    logic [W-1:0]  r_s1_half_x;
    logic [W-1:0]  r_s1_half_y;
    logic          r_s1_neg_x;
    logic          r_s1_neg_y;
    t_coord        r_s1_base_x;
    t_coord        r_s1_base_y;
    logic          r_s1_role;
    logic          r_s1_end;

    // stage 2: divide by three via reciprocal
    logic [2*W-1:0] w_prod_x;
    logic [2*W-1:0] w_prod_y;

    logic          r_s2_valid;
    logic [W-2:0]  r_s2_q_x;
    logic [W-2:0]  r_s2_q_y;
    logic          r_s2_neg_x;
    logic          r_s2_neg_y;
    t_coord        r_s2_base_x;
    t_coord        r_s2_base_y;
    logic          r_s2_role;
    logic          r_s2_end;

    // stage 3: offset and saturate
    logic [W:0]        w_q_x;
    logic [W:0]        w_q_y;
    logic signed [W:0] w_sum_x;
    logic signed [W:0] w_sum_y;
    t_coord            w_sat_x;
    t_coord            w_sat_y;

    logic   r_out_valid;
    t_point r_out;

    assign o_adv       = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_diff_x = {i_issue.hi_x[W-1], i_issue.hi_x} - {i_issue.lo_x[W-1], i_issue.lo_x};
    assign w_diff_y = {i_issue.hi_y[W-1], i_issue.hi_y} - {i_issue.lo_y[W-1], i_issue.lo_y};
    assign w_mag_x  = w_diff_x[W] ? (W+1)'(-w_diff_x) : w_diff_x;
    assign w_mag_y  = w_diff_y[W] ? (W+1)'(-w_diff_y) : w_diff_y;

    assign w_prod_x = (2*W)'(r_s1_half_x) * (2*W)'(CRB_RECIP3);
    assign w_prod_y = (2*W)'(r_s1_half_y) * (2*W)'(CRB_RECIP3);

    assign w_q_x   = {2'b00, r_s2_q_x};
    assign w_q_y   = {2'b00, r_s2_q_y};
    assign w_sum_x = {r_s2_base_x[W-1], r_s2_base_x} + (r_s2_neg_x ? -w_q_x : w_q_x);
    assign w_sum_y = {r_s2_base_y[W-1], r_s2_base_y} + (r_s2_neg_y ? -w_q_y : w_q_y);

    always_comb begin
        w_sat_x = w_sum_x[W-1:0];
        if (w_sum_x[W] != w_sum_x[W-1]) begin
            w_sat_x = w_sum_x[W] ? CRB_COORD_MIN : CRB_COORD_MAX;
        end
        w_sat_y = w_sum_y[W-1:0];
        if (w_sum_y[W] != w_sum_y[W-1]) begin
            w_sat_y = w_sum_y[W] ? CRB_COORD_MIN : CRB_COORD_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_s1_valid  <= i_issue.valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_s1_half_x <= w_mag_x[W:1];
            r_s1_half_y <= w_mag_y[W:1];
            r_s1_neg_x  <= w_diff_x[W] ^ i_issue.sub;
            r_s1_neg_y  <= w_diff_y[W] ^ i_issue.sub;
            r_s1_base_x <= i_issue.base_x;
            r_s1_base_y <= i_issue.base_y;
            r_s1_role   <= i_issue.role;
            r_s1_end    <= i_issue.run_end;

            r_s2_q_x    <= w_prod_x[2*W-1:CRB_RECIP_SHIFT];
            r_s2_q_y    <= w_prod_y[2*W-1:CRB_RECIP_SHIFT];
            r_s2_neg_x  <= r_s1_neg_x;
            r_s2_neg_y  <= r_s1_neg_y;
            r_s2_base_x <= r_s1_base_x;
            r_s2_base_y <= r_s1_base_y;
            r_s2_role   <= r_s1_role;
            r_s2_end    <= r_s1_end;

            r_out.px         <= w_sat_x;
            r_out.py         <= w_sat_y;
            r_out.point_role <= r_s2_role;
            r_out.run_end    <= r_s2_end;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/catmull_rom_to_bezier_smoother_core.sv */
// channel | dir | handshake                 | beat
// in      | in  | i_in_valid / o_in_ready   | t_vertex: vx, vy, vlast
// out     | out | o_out_valid / i_out_ready | t_point: px, py, point_role, run_end
// cfg     | in  | i_cfg_valid / o_cfg_ready | smooth_enable, always ready
//
// the job sequencer issues output points in turn and holds on an output stall;
// with smoothing enabled a vertex yields 3 points, 4 on the third, 6 or 7 on
// the last, and the first two yield none; each point leaves through registered
// chord, divide and offset/saturate stages; synchronous active-low reset clears
// window, count, enable and pipe valids; an output stall freezes all stages; a
// new vertex is taken as the last point of the current one issues

`default_nettype none

`include "catmull_rom_to_bezier_smoother_core_defines.svh"

module catmull_rom_to_bezier_smoother_core
    import crb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_vertex i_in_data,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_point       o_out_data,
    input  wire logic    i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire logic    i_cfg_data
);

    logic      w_accept;
    logic      w_job_load;
    t_job      w_job;
    t_seen     w_seen;
    logic      w_adv;
    t_seq_stat w_seq_stat;
    t_issue    w_issue;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = w_seq_stat.free;
    assign w_accept    = i_in_valid && o_in_ready;

    crb_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_accept),
        .i_vertex   (i_in_data),
        .o_job_load (w_job_load),
        .o_job      (w_job),
        .o_seen     (w_seen)
    );

    crb_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept && w_job_load),
        .i_job   (w_job),
        .i_adv   (w_adv),
        .o_stat  (w_seq_stat),
        .o_issue (w_issue)
    );

    crb_point u_point (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (w_issue),
        .i_out_ready (i_out_ready),
        .o_adv       (w_adv),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    `CRB_CHECK_NEXT(a_last_clears_count, w_accept && i_in_data.vlast, w_seen == '0)
    `CRB_CHECK_SAME(a_ready_busy_needs_adv, o_in_ready && w_seq_stat.busy, w_adv)
    `CRB_CHECK_SAME(a_control_not_end, o_out_valid && o_out_data.point_role, !o_out_data.run_end)

endmodule

`default_nettype wire
